### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ROM search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OWS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define OWS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/ows_pkg.sv
// ----------------------------------------------------------------------------
// ows_pkg
// Types and constants shared by the 1-Wire ROM search decision engine.
// ----------------------------------------------------------------------------
package ows_pkg;

  localparam int ROM_BITS   = 64;
  localparam int POS_W      = 7;
  localparam int SHIFT_W    = 6;
  localparam int FAM_DISC_W = 4;
  localparam int FAMILY_W   = 8;

  // Last search bit inside the family byte, plus one
  localparam logic [POS_W-1:0] FAMILY_END = POS_W'(9);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(ROM_BITS);
  localparam logic [POS_W-1:0] FIRST_POS  = POS_W'(1);

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_BIT_PAIR = 2'd1,
    OP_TARGET   = 2'd2,
    OP_SKIP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_PRESENCE = 3'd1,
    ST_NO_RESPONSE = 3'd2,
    ST_IGNORED     = 3'd3,
    ST_ENDED       = 3'd4,
    ST_ZERO_FAMILY = 3'd5
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic                restart;
    logic                presence;
    logic                id_bit;
    logic                complement_bit;
    logic [FAMILY_W-1:0] family_code;
  } item_t;

  typedef struct packed {
    logic                write_valid;
    logic                write_bit;
    logic                search_done;
    logic                device_found;
    logic [ROM_BITS-1:0] rom_id;
    logic                last_device;
    status_t             status;
  } result_t;

  typedef struct packed {
    logic [ROM_BITS-1:0]   rom_code;
    logic [POS_W-1:0]      last_discrepancy;
    logic [FAM_DISC_W-1:0] last_family_discrepancy;
    logic                  last_device_mark;
    logic [POS_W-1:0]      bit_position;
    logic [POS_W-1:0]      last_zero_position;
    logic                  pass_active;
  } search_state_t;

endpackage

### hw/rtl/onewire_rom_search_unit.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_unit
// Decision engine of the 1-Wire ROM search with registered item and result.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_ready/item) carries begin, bit-pair,
//   target-family and family-skip operations. Every item produces exactly
//   one result on the result channel (result_valid/result_ready/result):
//   the direction bit to write back, pass end and found flags, the ROM code
//   and a status code.
//   Each item passes through the item register and then the result
//   register: its transfer loads the item register, and the result
//   register is loaded once the result channel has room.
//   Throughput: one item per cycle while the receiver takes results; the
//   search state is updated as the item moves into the result register.
//   Reset (rst, synchronous) empties both registers and puts the search
//   state at ROM zero, no discrepancies, bit position one, no pass.
//   When the receiver stalls, the result is held and one more item waits
//   in the item register; item_ready drops only once both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onewire_rom_search_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  ows_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output ows_pkg::result_t result
);

  ows_pkg::item_t         item_q;
  logic                   item_vld;
  ows_pkg::result_t       result_q;
  logic                   result_vld;
  ows_pkg::search_state_t state;
  ows_pkg::search_state_t state_next;
  ows_pkg::result_t       res_next;
  logic                   advance;

  // Move the held item into the result register when it has room
  assign advance    = item_vld && (!result_vld || result_ready);
  assign item_ready = !item_vld || advance;

  ows_step u_step (
    .state      (state),
    .item       (item_q),
    .state_next (state_next),
    .res        (res_next)
  );

  // Hold the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item_ready) begin
      item_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Commit the step: update search state and load the result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_vld                    <= 1'b0;
      state.rom_code                <= '0;
      state.last_discrepancy        <= '0;
      state.last_family_discrepancy <= '0;
      state.last_device_mark        <= 1'b0;
      state.bit_position            <= ows_pkg::FIRST_POS;
      state.last_zero_position      <= '0;
      state.pass_active             <= 1'b0;
    end else if (advance) begin
      result_vld <= 1'b1;
      state      <= state_next;
    end else if (result_ready) begin
      result_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= res_next;
    end
  end

  assign result_valid = result_vld;
  assign result       = result_q;

  // Checks
  `OWS_ASSERT_IMP(a_found_ends_pass, clk, rst,
    result_vld && result_q.device_found, result_q.search_done)
  `OWS_ASSERT_IMP(a_write_only_ok, clk, rst,
    result_vld && result_q.write_valid,
    result_q.status == ows_pkg::ST_OK || result_q.status == ows_pkg::ST_ZERO_FAMILY)
  `OWS_ASSERT_IMP(a_pos_range, clk, rst, 1'b1,
    state.bit_position != '0 && state.bit_position <= ows_pkg::LAST_POS)
  `OWS_ASSERT_IMP(a_fam_disc_range, clk, rst, 1'b1,
    state.last_family_discrepancy < ows_pkg::FAM_DISC_W'(ows_pkg::FAMILY_END))
  `OWS_ASSERT_IMP(a_ready_when_free, clk, rst, !result_vld, item_ready)
  `OWS_ASSERT_NXT(a_commit_shows, clk, rst, advance, result_vld)

endmodule

### hw/rtl/ows_step.sv
// ----------------------------------------------------------------------------
// ows_step
// Combinational decision step: applies one item to the search state and
// forms the result item.
// ----------------------------------------------------------------------------
module ows_step (
  input  ows_pkg::search_state_t state,
  input  ows_pkg::item_t         item,
  output ows_pkg::search_state_t state_next,
  output ows_pkg::result_t       res
);

  logic [ows_pkg::POS_W-1:0]    pos;
  logic [ows_pkg::SHIFT_W-1:0]  sh;
  logic [ows_pkg::ROM_BITS-1:0] mask;
  logic                         dir;
  logic                         cur_bit;

  // Locate the ROM bit for the current search position
  always_comb begin
    pos     = state.bit_position;
    sh      = ows_pkg::SHIFT_W'(pos - ows_pkg::FIRST_POS);
    mask    = ows_pkg::ROM_BITS'(1) << sh;
    cur_bit = state.rom_code[sh];
  end

  // Decide the step
  always_comb begin
    state_next = state;
    res        = '0;
    res.status = ows_pkg::ST_OK;
    dir        = 1'b0;

    unique case (item.operation)
      ows_pkg::OP_BEGIN: begin
        if (item.restart) begin
          state_next.last_discrepancy        = '0;
          state_next.last_family_discrepancy = '0;
          state_next.last_device_mark        = 1'b0;
        end
        state_next.pass_active = 1'b0;
        if (state_next.last_device_mark) begin
          state_next.last_discrepancy        = '0;
          state_next.last_family_discrepancy = '0;
          state_next.last_device_mark        = 1'b0;
          res.search_done = 1'b1;
          res.status      = ows_pkg::ST_ENDED;
        end else if (!item.presence) begin
          state_next.last_discrepancy        = '0;
          state_next.last_family_discrepancy = '0;
          state_next.last_device_mark        = 1'b0;
          res.search_done = 1'b1;
          res.status      = ows_pkg::ST_NO_PRESENCE;
        end else begin
          state_next.pass_active        = 1'b1;
          state_next.bit_position       = ows_pkg::FIRST_POS;
          state_next.last_zero_position = '0;
        end
      end

      ows_pkg::OP_BIT_PAIR: begin
        if (!state.pass_active) begin
          res.status = ows_pkg::ST_IGNORED;
        end else if (item.id_bit && item.complement_bit) begin
          // Nobody on the bus drove the slot pair
          state_next.pass_active             = 1'b0;
          state_next.last_discrepancy        = '0;
          state_next.last_family_discrepancy = '0;
          state_next.last_device_mark        = 1'b0;
          res.search_done = 1'b1;
          res.status      = ows_pkg::ST_NO_RESPONSE;
        end else begin
          if (item.id_bit != item.complement_bit) begin
            dir = item.id_bit;
          end else begin
            // Discrepancy: follow the previous path, take one at the last
            // discrepancy, zero beyond it
            if (pos < state.last_discrepancy) begin
              dir = cur_bit;
            end else begin
              dir = (pos == state.last_discrepancy);
            end
            if (!dir) begin
              state_next.last_zero_position = pos;
              if (pos < ows_pkg::FAMILY_END) begin
                state_next.last_family_discrepancy = ows_pkg::FAM_DISC_W'(pos);
              end
            end
          end
          if (dir) begin
            state_next.rom_code = state.rom_code | mask;
          end else begin
            state_next.rom_code = state.rom_code & ~mask;
          end
          res.write_valid = 1'b1;
          res.write_bit   = dir;
          if (pos >= ows_pkg::LAST_POS) begin
            // Close the pass
            state_next.pass_active      = 1'b0;
            state_next.bit_position     = ows_pkg::FIRST_POS;
            res.search_done             = 1'b1;
            state_next.last_discrepancy = state_next.last_zero_position;
            if (state_next.last_zero_position == '0) begin
              state_next.last_device_mark = 1'b1;
            end
            if (state_next.rom_code[ows_pkg::FAMILY_W-1:0] == '0) begin
              state_next.last_discrepancy        = '0;
              state_next.last_family_discrepancy = '0;
              state_next.last_device_mark        = 1'b0;
              res.status = ows_pkg::ST_ZERO_FAMILY;
            end else begin
              res.device_found = 1'b1;
            end
          end else begin
            state_next.bit_position = pos + ows_pkg::FIRST_POS;
          end
        end
      end

      ows_pkg::OP_TARGET: begin
        if (state.pass_active) begin
          res.status = ows_pkg::ST_IGNORED;
        end else begin
          state_next.rom_code = ows_pkg::ROM_BITS'(item.family_code);
          state_next.last_discrepancy        = ows_pkg::LAST_POS;
          state_next.last_family_discrepancy = '0;
          state_next.last_device_mark        = 1'b0;
        end
      end

      ows_pkg::OP_SKIP: begin
        if (state.pass_active) begin
          res.status = ows_pkg::ST_IGNORED;
        end else begin
          state_next.last_discrepancy =
            ows_pkg::POS_W'(state.last_family_discrepancy);
          state_next.last_family_discrepancy = '0;
          if (state.last_family_discrepancy == '0) begin
            state_next.last_device_mark = 1'b1;
          end
        end
      end

      default: begin
        res.status = ows_pkg::ST_IGNORED;
      end
    endcase

    res.rom_id      = state_next.rom_code;
    res.last_device = state_next.last_device_mark;
  end

endmodule

### verif/rom_search_checker.sv
// ----------------------------------------------------------------------------
// rom_search_checker
// Watches the item and result channels of the ROM search unit, keeps its own
// copy of the search state, works out the result of every item transfer and
// compares each result transfer with the oldest outstanding one.
// ----------------------------------------------------------------------------
module rom_search_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  ows_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  ows_pkg::result_t result,
  output int               error_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Search state as the block should hold it
  logic [ows_pkg::ROM_BITS-1:0]   rom_reg      = '0;
  logic [ows_pkg::POS_W-1:0]      disc_pos     = '0;
  logic [ows_pkg::FAM_DISC_W-1:0] fam_disc_pos = '0;
  logic                           last_dev     = 1'b0;
  logic [ows_pkg::POS_W-1:0]      bit_pos      = ows_pkg::FIRST_POS;
  logic [ows_pkg::POS_W-1:0]      zero_pos     = '0;
  logic                           in_pass      = 1'b0;

  ows_pkg::result_t expected_results[$];

  task automatic report_error(input string msg);
    $display("[%0t ns] %s", $time, msg);
    error_count++;
  endtask

  function automatic void forget_discrepancies();
    disc_pos     = '0;
    fam_disc_pos = '0;
    last_dev     = 1'b0;
  endfunction

  // Apply one item to the state and return the result it should produce
  function automatic ows_pkg::result_t search_step(input ows_pkg::item_t it);
    ows_pkg::result_t            r;
    logic [ows_pkg::POS_W-1:0]   pos;
    logic [ows_pkg::SHIFT_W-1:0] sh;
    logic                        dir;
    r        = '0;
    r.status = ows_pkg::ST_OK;
    case (it.operation)
      ows_pkg::OP_BEGIN: begin
        if (it.restart) forget_discrepancies();
        in_pass = 1'b0;
        if (last_dev) begin
          forget_discrepancies();
          r.search_done = 1'b1;
          r.status      = ows_pkg::ST_ENDED;
        end else if (!it.presence) begin
          forget_discrepancies();
          r.search_done = 1'b1;
          r.status      = ows_pkg::ST_NO_PRESENCE;
        end else begin
          in_pass  = 1'b1;
          bit_pos  = ows_pkg::FIRST_POS;
          zero_pos = '0;
        end
      end
      ows_pkg::OP_BIT_PAIR: begin
        if (!in_pass) begin
          r.status = ows_pkg::ST_IGNORED;
        end else if (it.id_bit && it.complement_bit) begin
          // nobody answered the slot pair
          in_pass = 1'b0;
          forget_discrepancies();
          r.search_done = 1'b1;
          r.status      = ows_pkg::ST_NO_RESPONSE;
        end else begin
          pos = bit_pos;
          sh  = ows_pkg::SHIFT_W'(pos - ows_pkg::FIRST_POS);
          if (it.id_bit != it.complement_bit) begin
            dir = it.id_bit;
          end else begin
            // conflict: replay below the last discrepancy, take one at it
            if (pos < disc_pos) dir = rom_reg[sh];
            else dir = (pos == disc_pos);
            if (!dir) begin
              zero_pos = pos;
              if (pos < ows_pkg::FAMILY_END) fam_disc_pos = pos[ows_pkg::FAM_DISC_W-1:0];
            end
          end
          rom_reg[sh]   = dir;
          r.write_valid = 1'b1;
          r.write_bit   = dir;
          if (pos >= ows_pkg::LAST_POS) begin
            in_pass       = 1'b0;
            bit_pos       = ows_pkg::FIRST_POS;
            r.search_done = 1'b1;
            disc_pos      = zero_pos;
            if (disc_pos == '0) last_dev = 1'b1;
            if (rom_reg[ows_pkg::FAMILY_W-1:0] == '0) begin
              forget_discrepancies();
              r.status = ows_pkg::ST_ZERO_FAMILY;
            end else begin
              r.device_found = 1'b1;
            end
          end else begin
            bit_pos = pos + ows_pkg::FIRST_POS;
          end
        end
      end
      ows_pkg::OP_TARGET: begin
        if (in_pass) begin
          r.status = ows_pkg::ST_IGNORED;
        end else begin
          rom_reg      = ows_pkg::ROM_BITS'(it.family_code);
          disc_pos     = ows_pkg::LAST_POS;
          fam_disc_pos = '0;
          last_dev     = 1'b0;
        end
      end
      default: begin
        if (in_pass) begin
          r.status = ows_pkg::ST_IGNORED;
        end else begin
          disc_pos     = ows_pkg::POS_W'(fam_disc_pos);
          fam_disc_pos = '0;
          if (disc_pos == '0) last_dev = 1'b1;
        end
      end
    endcase
    r.rom_id      = rom_reg;
    r.last_device = last_dev;
    return r;
  endfunction

  // Compare finished results first, then queue the new item's result
  always @(posedge clk) begin
    ows_pkg::result_t want;
    if (rst) begin
      rom_reg  = '0;
      forget_discrepancies();
      bit_pos  = ows_pkg::FIRST_POS;
      zero_pos = '0;
      in_pass  = 1'b0;
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_error("result transfer with no result outstanding");
        end else begin
          want = expected_results.pop_front();
          if (result.write_valid !== want.write_valid)
            report_error($sformatf("write_valid got %b expected %b",
                                   result.write_valid, want.write_valid));
          if (result.write_bit !== want.write_bit)
            report_error($sformatf("write_bit got %b expected %b",
                                   result.write_bit, want.write_bit));
          if (result.search_done !== want.search_done)
            report_error($sformatf("search_done got %b expected %b",
                                   result.search_done, want.search_done));
          if (result.device_found !== want.device_found)
            report_error($sformatf("device_found got %b expected %b",
                                   result.device_found, want.device_found));
          if (result.rom_id !== want.rom_id)
            report_error($sformatf("rom_id got %h expected %h",
                                   result.rom_id, want.rom_id));
          if (result.last_device !== want.last_device)
            report_error($sformatf("last_device got %b expected %b",
                                   result.last_device, want.last_device));
          if (result.status !== want.status)
            report_error($sformatf("status got %0d expected %0d",
                                   result.status, want.status));
        end
      end
      if (item_valid && item_ready) expected_results.push_back(search_step(item));
    end
    pending = expected_results.size();
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the ROM search unit with a short directed sequence and then with
// random search passes over simulated bus populations, target setups, family
// skips, cut-off passes and noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  ows_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  ows_pkg::result_t result;

  int error_count;
  int pending;
  int sent          = 0;
  bit calm          = 1'b0;
  bit hold_results  = 1'b0;
  bit conflict_at [ows_pkg::ROM_BITS];

  onewire_rom_search_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  rom_search_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .error_count  (error_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, calm stretches, and an occasional long hold-off
  initial begin
    int r;
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_results = 1'b0;
      end else if (calm) begin
        result_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          result_ready <= 1'b1;
          @(posedge clk);
        end else if (r < 94) begin
          result_ready <= 1'b0;
          @(posedge clk);
        end else begin
          result_ready <= 1'b0;
          repeat ($urandom_range(5, 30)) @(posedge clk);
        end
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input ows_pkg::item_t it);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  // Stop offering until every outstanding result has come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic ows_pkg::item_t random_item();
    logic [31:0] raw;
    raw = $urandom;
    return ows_pkg::item_t'(raw[$bits(ows_pkg::item_t)-1:0]);
  endfunction

  // Builders fill the unused fields with random bits
  function automatic ows_pkg::item_t begin_item(input bit restart, input bit presence);
    ows_pkg::item_t it;
    it           = random_item();
    it.operation = ows_pkg::OP_BEGIN;
    it.restart   = restart;
    it.presence  = presence;
    return it;
  endfunction

  function automatic ows_pkg::item_t pair_item(input bit id_bit,
                                               input bit complement_bit);
    ows_pkg::item_t it;
    it                = random_item();
    it.operation      = ows_pkg::OP_BIT_PAIR;
    it.id_bit         = id_bit;
    it.complement_bit = complement_bit;
    return it;
  endfunction

  function automatic ows_pkg::item_t target_item(
    input logic [ows_pkg::FAMILY_W-1:0] family_code);
    ows_pkg::item_t it;
    it             = random_item();
    it.operation   = ows_pkg::OP_TARGET;
    it.family_code = family_code;
    return it;
  endfunction

  function automatic ows_pkg::item_t skip_item();
    ows_pkg::item_t it;
    it           = random_item();
    it.operation = ows_pkg::OP_SKIP;
    return it;
  endfunction

  // Pick the ROM positions where devices on the bus disagree
  function automatic void new_bus();
    int n;
    foreach (conflict_at[i]) conflict_at[i] = 1'b0;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 1) != 0)
        conflict_at[$urandom_range(0, ows_pkg::FAMILY_W - 1)] = 1'b1;
      else
        conflict_at[$urandom_range(ows_pkg::FAMILY_W, ows_pkg::ROM_BITS - 1)] = 1'b1;
    end
  endfunction

  // Begin a pass and feed bit pairs; stop_at below 64 cuts the pass short
  task automatic run_search_pass(input bit restart, input bit zero_family,
                                 input int stop_at);
    int pos;
    bit idb;
    send_item(begin_item(restart, 1'b1));
    for (pos = 0; pos < stop_at; pos++) begin
      if (zero_family && pos < ows_pkg::FAMILY_W) begin
        send_item(pair_item(1'b0, 1'b1));
      end else if (conflict_at[pos]) begin
        send_item(pair_item(1'b0, 1'b0));
      end else if ($urandom_range(0, 499) == 0) begin
        send_item(pair_item(1'b1, 1'b1));
      end else begin
        idb = ($urandom_range(0, 1) != 0);
        send_item(pair_item(idb, !idb));
      end
    end
  endtask

  // Stimulus
  initial begin
    int kind;
    int round;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle operations, ended search, aborted passes, extremes
    send_item(pair_item(1'b0, 1'b0));
    send_item(skip_item());
    send_item(begin_item(1'b0, 1'b1));
    send_item(skip_item());
    send_item(begin_item(1'b1, 1'b1));
    send_item(target_item(8'hFF));
    send_item(skip_item());
    send_item(pair_item(1'b1, 1'b0));
    send_item(pair_item(1'b0, 1'b1));
    send_item(pair_item(1'b0, 1'b0));
    send_item(begin_item(1'b0, 1'b1));
    send_item(pair_item(1'b1, 1'b1));
    send_item(pair_item(1'b1, 1'b0));
    send_item(begin_item(1'b1, 1'b0));
    send_item(target_item(8'h00));
    send_item(target_item(8'hFF));
    send_item(begin_item(1'b0, 1'b1));
    send_item(pair_item(1'b0, 1'b0));
    send_item(pair_item(1'b0, 1'b0));
    drain();

    // Random: mostly full passes over a bus, with setup, skips and noise
    new_bus();
    round = 0;
    while (sent < 770) begin
      calm = ($urandom_range(0, 3) == 0);
      if (round % 12 == 2) begin
        calm         = 1'b1;
        hold_results = 1'b1;
      end
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2, 3:
          run_search_pass($urandom_range(0, 5) == 0, 1'b0, ows_pkg::ROM_BITS);
        4: begin
          new_bus();
          run_search_pass(1'b1, 1'b0, ows_pkg::ROM_BITS);
        end
        5: begin
          drain();
          send_item(target_item(($urandom_range(0, 4) == 0) ? 8'h00 :
                                ows_pkg::FAMILY_W'($urandom_range(0, 255))));
          run_search_pass(1'b0, 1'b0, ows_pkg::ROM_BITS);
        end
        6: begin
          send_item(skip_item());
          run_search_pass(1'b0, 1'b0, ows_pkg::ROM_BITS);
        end
        7: run_search_pass($urandom_range(0, 1) != 0, 1'b1, ows_pkg::ROM_BITS);
        8: run_search_pass($urandom_range(0, 1) != 0, 1'b0,
                           $urandom_range(1, ows_pkg::ROM_BITS - 1));
        9, 10: repeat ($urandom_range(1, 8)) send_item(random_item());
        default: send_item(begin_item($urandom_range(0, 1) != 0, 1'b0));
      endcase
      round++;
    end

    // Let the last results come back, then give the verdict
    calm = 1'b1;
    item_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ows_pkg.sv
hw/rtl/ows_step.sv
hw/rtl/onewire_rom_search_unit.sv
verif/rom_search_checker.sv
verif/tb.sv
